>>> sv/smcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcs_pkg
// Types and constants shared by the serial MRAM command sequencer.
// ----------------------------------------------------------------------------
package smcs_pkg;

    localparam int IN_DATA_W  = 56;
    localparam int IN_USED_W  = 50;
    localparam int OUT_DATA_W = 88;

    // Event selector carried in the input tuser
    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_READ   = 2'd1,
        OP_WRITE  = 2'd2,
        OP_FINISH = 2'd3
    } op_t;

    // Sequencer phase
    typedef enum logic [2:0] {
        PH_NOINIT = 3'd0,
        PH_IDLE   = 3'd1,
        PH_RX     = 3'd2,
        PH_WREN   = 3'd3,
        PH_TX     = 3'd4,
        PH_WRDI   = 3'd5,
        PH_ERROR  = 3'd6,
        PH_INIT   = 3'd7
    } phase_t;

    // Completion codes of a report
    typedef enum logic [2:0] {
        CC_SUCCESS   = 3'd0,
        CC_BUSY      = 3'd1,
        CC_NO_BUFFER = 3'd2,
        CC_LENGTH    = 3'd3,
        CC_ADDRESS   = 3'd4,
        CC_REFUSED   = 3'd5,
        CC_DEV_BAD   = 3'd6
    } ccode_t;

    // SPI opcodes
    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_WRITE = 8'h02;
    localparam logic [7:0] CMD_WRDI  = 8'h04;

    localparam logic       KIND_DESC   = 1'b0;
    localparam logic       KIND_REPORT = 1'b1;

    localparam logic [24:0] MEM_LIMIT   = 25'h020000;
    localparam logic [8:0]  HDR_BYTES   = 9'd4;

    // One result beat
    typedef struct packed {
        logic        kind;
        logic [7:0]  command;
        logic        address_top;
        logic [7:0]  address_mid;
        logic [7:0]  address_bottom;
        logic [8:0]  send_count;
        logic [8:0]  receive_count;
        logic [2:0]  completion_code;
        logic [23:0] request_address;
        logic [15:0] request_length;
        logic        data_ready;
    } result_t;

    // One input event
    typedef struct packed {
        op_t         operation;
        logic [23:0] address;
        logic [15:0] length;
        logic        buffer_present;
        logic        transfer_accepted;
        logic [7:0]  status_byte;
    } event_t;

    // Sequencer state update
    typedef struct packed {
        phase_t      phase;
        logic        save;
    } step_ctl_t;

endpackage

>>> sv/smcs_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcs_step
// Combinational step: next phase and result beat for one event.
// ----------------------------------------------------------------------------
module smcs_step #(
    parameter int MAX_READ_BYTES  = 256,
    parameter int MAX_WRITE_BYTES = 256
) (
    input  smcs_pkg::event_t    ev,
    input  smcs_pkg::phase_t    phase,
    input  logic [16:0]         saved_address,
    input  logic [8:0]          saved_length,
    output smcs_pkg::step_ctl_t ctl,
    output logic                res_valid,
    output smcs_pkg::result_t   res
);

    logic [15:0]      max_len;
    logic [24:0]      end_address;
    smcs_pkg::ccode_t req_code;

    assign max_len     = (ev.operation == smcs_pkg::OP_READ) ? 16'(MAX_READ_BYTES)
                                                             : 16'(MAX_WRITE_BYTES);
    assign end_address = {1'b0, ev.address} + {9'd0, ev.length};

    // Request checks, in priority order
    always_comb
    begin
        if (phase != smcs_pkg::PH_IDLE)
            req_code = smcs_pkg::CC_BUSY;
        else if (!ev.buffer_present)
            req_code = smcs_pkg::CC_NO_BUFFER;
        else if (ev.length > max_len)
            req_code = smcs_pkg::CC_LENGTH;
        else if (end_address > smcs_pkg::MEM_LIMIT)
            req_code = smcs_pkg::CC_ADDRESS;
        else if (!ev.transfer_accepted)
            req_code = smcs_pkg::CC_REFUSED;
        else
            req_code = smcs_pkg::CC_SUCCESS;
    end

    // Next phase
    always_comb
    begin
        ctl.phase = phase;
        ctl.save  = 1'b0;
        unique case (ev.operation)
            smcs_pkg::OP_INIT:
                ctl.phase = ev.transfer_accepted ? smcs_pkg::PH_INIT : smcs_pkg::PH_ERROR;
            smcs_pkg::OP_READ,
            smcs_pkg::OP_WRITE:
            begin
                if (req_code == smcs_pkg::CC_SUCCESS)
                begin
                    ctl.save  = 1'b1;
                    ctl.phase = (ev.operation == smcs_pkg::OP_READ) ? smcs_pkg::PH_RX
                                                                    : smcs_pkg::PH_WREN;
                end
            end
            default:
            begin
                unique case (phase)
                    smcs_pkg::PH_INIT:
                        ctl.phase = (ev.status_byte == 8'd0) ? smcs_pkg::PH_IDLE
                                                             : smcs_pkg::PH_ERROR;
                    smcs_pkg::PH_RX,
                    smcs_pkg::PH_WRDI:
                        ctl.phase = smcs_pkg::PH_IDLE;
                    smcs_pkg::PH_WREN:
                        ctl.phase = ev.transfer_accepted ? smcs_pkg::PH_TX : smcs_pkg::PH_IDLE;
                    smcs_pkg::PH_TX:
                        ctl.phase = ev.transfer_accepted ? smcs_pkg::PH_WRDI : smcs_pkg::PH_IDLE;
                    default:
                        ctl.phase = phase;
                endcase
            end
        endcase
    end

    // Result beat
    always_comb
    begin
        res       = '0;
        res_valid = 1'b1;
        unique case (ev.operation)
            smcs_pkg::OP_INIT:
            begin
                if (ev.transfer_accepted)
                begin
                    res.kind          = smcs_pkg::KIND_DESC;
                    res.command       = smcs_pkg::CMD_RDSR;
                    res.send_count    = 9'd1;
                    res.receive_count = 9'd1;
                end
                else
                begin
                    res.kind            = smcs_pkg::KIND_REPORT;
                    res.completion_code = smcs_pkg::CC_REFUSED;
                end
            end
            smcs_pkg::OP_READ,
            smcs_pkg::OP_WRITE:
            begin
                if (req_code != smcs_pkg::CC_SUCCESS)
                begin
                    res.kind            = smcs_pkg::KIND_REPORT;
                    res.completion_code = req_code;
                    res.request_address = ev.address;
                    res.request_length  = ev.length;
                end
                else if (ev.operation == smcs_pkg::OP_READ)
                begin
                    res.command        = smcs_pkg::CMD_READ;
                    res.address_top    = ev.address[16];
                    res.address_mid    = ev.address[15:8];
                    res.address_bottom = ev.address[7:0];
                    res.send_count     = smcs_pkg::HDR_BYTES;
                    res.receive_count  = ev.length[8:0];
                end
                else
                begin
                    res.command    = smcs_pkg::CMD_WREN;
                    res.send_count = 9'd1;
                end
            end
            default:
            begin
                unique case (phase)
                    smcs_pkg::PH_INIT:
                    begin
                        res.kind            = smcs_pkg::KIND_REPORT;
                        res.completion_code = (ev.status_byte == 8'd0) ? smcs_pkg::CC_SUCCESS
                                                                       : smcs_pkg::CC_DEV_BAD;
                    end
                    smcs_pkg::PH_RX,
                    smcs_pkg::PH_WRDI:
                    begin
                        res.kind            = smcs_pkg::KIND_REPORT;
                        res.completion_code = smcs_pkg::CC_SUCCESS;
                        res.request_address = {7'd0, saved_address};
                        res.request_length  = {7'd0, saved_length};
                        res.data_ready      = 1'b1;
                    end
                    smcs_pkg::PH_WREN,
                    smcs_pkg::PH_TX:
                    begin
                        if (!ev.transfer_accepted)
                        begin
                            res.kind            = smcs_pkg::KIND_REPORT;
                            res.completion_code = smcs_pkg::CC_REFUSED;
                            res.request_address = {7'd0, saved_address};
                            res.request_length  = {7'd0, saved_length};
                        end
                        else if (phase == smcs_pkg::PH_WREN)
                        begin
                            res.command        = smcs_pkg::CMD_WRITE;
                            res.address_top    = saved_address[16];
                            res.address_mid    = saved_address[15:8];
                            res.address_bottom = saved_address[7:0];
                            res.send_count     = saved_length + smcs_pkg::HDR_BYTES;
                        end
                        else
                        begin
                            res.command    = smcs_pkg::CMD_WRDI;
                            res.send_count = 9'd1;
                        end
                    end
                    default:
                        res_valid = 1'b0;
                endcase
            end
        endcase
    end

endmodule

>>> sv/spi_mram_command_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_mram_command_sequencer
// Event-driven command sequencer for a serial MRAM behind an SPI engine.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries events: tuser selects init, read request,
//   write request or transfer finished; tdata carries the request fields,
//   the SPI engine's accept flag and the received status byte.
//   Master stream m_axis returns at most one beat per event: tuser = 0 is
//   the descriptor of the next SPI transfer, tuser = 1 a completion report.
//   Init reads the status register; a read goes out as one frame; a write
//   runs write-enable, data frame, write-disable, each step kicked by a
//   transfer-finished event.
//   Path: an event lands in the input register when it is accepted, and
//   its result is loaded into the output register once that slot is free.
//   Throughput: one event per cycle while the output is not stalled, set by
//   the single-pass step logic between the two registers. Events that cause
//   no result never wait. A stalled m_axis_tready holds the output beat; the
//   input register can still take one more event, then s_axis_tready drops
//   until the output drains.
//   Reset: phase becomes not initialized, saved request cleared, both
//   registers empty.
// ----------------------------------------------------------------------------
module spi_mram_command_sequencer #(
    parameter int MAX_READ_BYTES  = 256,
    parameter int MAX_WRITE_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [23:0] address, [39:24] length, [40] buffer_present,
    // [41] transfer_accepted, [49:42] status_byte, [55:50] zero
    input  logic [smcs_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] command, [8] address_top, [16:9] address_mid,
    // [24:17] address_bottom, [33:25] send_count, [42:34] receive_count,
    // [45:43] completion_code, [69:46] request_address,
    // [85:70] request_length, [86] data_ready, [87] zero
    output logic [smcs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] kind
    output logic        m_axis_tuser
);

    // Input register
    logic                       in_valid_reg;
    logic [smcs_pkg::IN_USED_W-1:0] in_data_reg;
    logic [1:0]                 in_user_reg;

    // Sequencer state
    smcs_pkg::phase_t           phase_reg;
    logic [16:0]                saved_address_reg;
    logic [8:0]                 saved_length_reg;

    // Output register
    logic                       out_valid_reg;
    smcs_pkg::result_t          out_reg;

    smcs_pkg::event_t           ev;
    smcs_pkg::step_ctl_t        ctl;
    logic                       res_valid;
    smcs_pkg::result_t          res;
    logic                       advance;
    logic                       in_take;

    assign ev.operation         = smcs_pkg::op_t'(in_user_reg);
    assign ev.address           = in_data_reg[23:0];
    assign ev.length            = in_data_reg[39:24];
    assign ev.buffer_present    = in_data_reg[40];
    assign ev.transfer_accepted = in_data_reg[41];
    assign ev.status_byte       = in_data_reg[49:42];

    smcs_step #(
        .MAX_READ_BYTES  (MAX_READ_BYTES),
        .MAX_WRITE_BYTES (MAX_WRITE_BYTES)
    ) u_step (
        .ev            (ev),
        .phase         (phase_reg),
        .saved_address (saved_address_reg),
        .saved_length  (saved_length_reg),
        .ctl           (ctl),
        .res_valid     (res_valid),
        .res           (res)
    );

    // Retire the held event once its result has a free output slot
    assign advance       = in_valid_reg && (!res_valid || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= s_axis_tdata[smcs_pkg::IN_USED_W-1:0];
            in_user_reg <= s_axis_tuser;
        end
    end

    // Advance sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= smcs_pkg::PH_NOINIT;
            saved_address_reg <= '0;
            saved_length_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg <= ctl.phase;
            if (ctl.save)
            begin
                saved_address_reg <= ev.address[16:0];
                saved_length_reg  <= ev.length[8:0];
            end
        end
    end

    // Output register: load a new beat or drop the delivered one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && res_valid)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {1'b0,
                            out_reg.data_ready,
                            out_reg.request_length,
                            out_reg.request_address,
                            out_reg.completion_code,
                            out_reg.receive_count,
                            out_reg.send_count,
                            out_reg.address_bottom,
                            out_reg.address_mid,
                            out_reg.address_top,
                            out_reg.command};

endmodule

>>> tb/tb_spi_mram_command_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spi_mram_command_sequencer
// Self-checking bench for the serial MRAM command sequencer: drives init,
// read, write and transfer-finished events on the input stream, predicts
// each output beat with a behavioral copy of the sequencer and compares it
// field by field. Directed tests cover the edge cases, then mostly
// well-formed random sequences with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_spi_mram_command_sequencer;

    import smcs_pkg::*;

    localparam int READ_MAX_BYTES  = 256;
    localparam int WRITE_MAX_BYTES = 256;
    localparam int RANDOM_ITEMS    = 804;
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [23:0] address, [39:24] length, [40] buffer_present,
    // [41] transfer_accepted, [49:42] status_byte, [55:50] zero
    logic [55:0] s_axis_tdata = '0;
    // [1:0] operation
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] command, [8] address_top, [16:9] address_mid,
    // [24:17] address_bottom, [33:25] send_count, [42:34] receive_count,
    // [45:43] completion_code, [69:46] request_address,
    // [85:70] request_length, [86] data_ready, [87] zero
    logic [87:0] m_axis_tdata;
    // [0] kind
    logic        m_axis_tuser;

    // Predicted sequencer state
    phase_t      seq_phase = PH_NOINIT;
    logic [16:0] held_address = '0;
    logic [8:0]  held_length = '0;

    result_t     pending_beats[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;

    // Idling controls for the two streams
    bit          tx_gaps_on = 1'b1;
    bit          rx_stalls_on = 1'b1;
    int          rx_stall_left = 0;
    int          rx_hold_cycles = 0;
    int          hold_requests = 0;
    int          hold_seen = 0;
    int          beats_seen = 0;
    int          beats_stalled = 0;

    spi_mram_command_sequencer #(
        .MAX_READ_BYTES  (READ_MAX_BYTES),
        .MAX_WRITE_BYTES (WRITE_MAX_BYTES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Sequencer prediction
    // ------------------------------------------------------------------------
    function automatic result_t make_descriptor(logic [7:0] cmd, logic [16:0] adr,
                                                logic [8:0] nsend, logic [8:0] nrecv);
        result_t r;
        r = '0;
        r.kind           = KIND_DESC;
        r.command        = cmd;
        r.address_top    = adr[16];
        r.address_mid    = adr[15:8];
        r.address_bottom = adr[7:0];
        r.send_count     = nsend;
        r.receive_count  = nrecv;
        return r;
    endfunction

    function automatic result_t make_report(ccode_t code, logic [23:0] adr,
                                            logic [15:0] len, logic ready);
        result_t r;
        r = '0;
        r.kind            = KIND_REPORT;
        r.completion_code = code;
        r.request_address = adr;
        r.request_length  = len;
        r.data_ready      = ready;
        return r;
    endfunction

    // Advance the predicted state by one event; return 1 if a beat results
    function automatic bit step_sequencer(input event_t ev, output result_t beat);
        logic [24:0] span;
        int          max_len;
        bit          has_beat;
        beat     = '0;
        has_beat = 1'b1;
        span     = {1'b0, ev.address} + {9'b0, ev.length};
        max_len  = (ev.operation == OP_READ) ? READ_MAX_BYTES : WRITE_MAX_BYTES;
        case (ev.operation)
            OP_INIT:
            begin
                // init abandons whatever runs, without a report for it
                if (!ev.transfer_accepted)
                begin
                    seq_phase = PH_ERROR;
                    beat = make_report(CC_REFUSED, '0, '0, 1'b0);
                end
                else
                begin
                    seq_phase = PH_INIT;
                    beat = make_descriptor(CMD_RDSR, '0, 9'd1, 9'd1);
                end
            end
            OP_READ, OP_WRITE:
            begin
                if (seq_phase != PH_IDLE)
                    beat = make_report(CC_BUSY, ev.address, ev.length, 1'b0);
                else if (!ev.buffer_present)
                    beat = make_report(CC_NO_BUFFER, ev.address, ev.length, 1'b0);
                else if (int'(ev.length) > max_len)
                    beat = make_report(CC_LENGTH, ev.address, ev.length, 1'b0);
                else if (span > MEM_LIMIT)
                    beat = make_report(CC_ADDRESS, ev.address, ev.length, 1'b0);
                else if (!ev.transfer_accepted)
                    beat = make_report(CC_REFUSED, ev.address, ev.length, 1'b0);
                else
                begin
                    held_address = ev.address[16:0];
                    held_length  = ev.length[8:0];
                    if (ev.operation == OP_READ)
                    begin
                        seq_phase = PH_RX;
                        beat = make_descriptor(CMD_READ, ev.address[16:0], HDR_BYTES,
                                               ev.length[8:0]);
                    end
                    else
                    begin
                        seq_phase = PH_WREN;
                        beat = make_descriptor(CMD_WREN, '0, 9'd1, 9'd0);
                    end
                end
            end
            default:
            begin
                case (seq_phase)
                    PH_INIT:
                    begin
                        if (ev.status_byte == 8'h00)
                        begin
                            seq_phase = PH_IDLE;
                            beat = make_report(CC_SUCCESS, '0, '0, 1'b0);
                        end
                        else
                        begin
                            seq_phase = PH_ERROR;
                            beat = make_report(CC_DEV_BAD, '0, '0, 1'b0);
                        end
                    end
                    PH_RX, PH_WRDI:
                    begin
                        seq_phase = PH_IDLE;
                        beat = make_report(CC_SUCCESS, {7'b0, held_address},
                                           {7'b0, held_length}, 1'b1);
                    end
                    PH_WREN, PH_TX:
                    begin
                        if (!ev.transfer_accepted)
                        begin
                            // a refused write stage drops back to idle
                            seq_phase = PH_IDLE;
                            beat = make_report(CC_REFUSED, {7'b0, held_address},
                                               {7'b0, held_length}, 1'b0);
                        end
                        else if (seq_phase == PH_WREN)
                        begin
                            seq_phase = PH_TX;
                            beat = make_descriptor(CMD_WRITE, held_address,
                                                   held_length + HDR_BYTES, 9'd0);
                        end
                        else
                        begin
                            seq_phase = PH_WRDI;
                            beat = make_descriptor(CMD_WRDI, '0, 9'd1, 9'd0);
                        end
                    end
                    // nothing in flight: the finish event is dropped
                    default: has_beat = 1'b0;
                endcase
            end
        endcase
        return has_beat;
    endfunction

    // ------------------------------------------------------------------------
    // Input stream driver
    // ------------------------------------------------------------------------
    function automatic event_t compose_event(op_t op, logic [23:0] adr, logic [15:0] len,
                                             logic buffer, logic accepted,
                                             logic [7:0] status);
        event_t ev;
        ev.operation         = op;
        ev.address           = adr;
        ev.length            = len;
        ev.buffer_present    = buffer;
        ev.transfer_accepted = accepted;
        ev.status_byte       = status;
        return ev;
    endfunction

    // Offer one event, hold it until accepted, then record its predicted beat
    task automatic send_event(input event_t ev);
        int      gap;
        result_t beat;
        gap = tx_gaps_on ? $urandom_range(0, 15) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, ev.status_byte, ev.transfer_accepted, ev.buffer_present,
                          ev.length, ev.address};
        s_axis_tuser  <= ev.operation;
        do @(posedge clk); while (!s_axis_tready);
        if (step_sequencer(ev, beat))
            pending_beats.push_back(beat);
    endtask

    // Drop valid, wait out every expected beat, then allow for stray ones
    task automatic wait_for_drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Output stream: ready generation and beat checking
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        // start a long hold when a test asks for one
        if (hold_requests != hold_seen)
        begin
            hold_seen      = hold_requests;
            rx_hold_cycles = HOLD_CYCLES;
        end
        // draw the stall before the next beat
        if (beats_seen != beats_stalled)
        begin
            beats_stalled = beats_seen;
            rx_stall_left = rx_stalls_on ? $urandom_range(0, 15) : 0;
        end
        if (rx_hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold_cycles--;
        end
        else if (rx_stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_stall_left--;
        end
        else
            m_axis_tready <= 1'b1;
    end

    function automatic void compare_field(string name, logic [23:0] want, logic [23:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : beat_checker
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind            = m_axis_tuser;
            got.command         = m_axis_tdata[7:0];
            got.address_top     = m_axis_tdata[8];
            got.address_mid     = m_axis_tdata[16:9];
            got.address_bottom  = m_axis_tdata[24:17];
            got.send_count      = m_axis_tdata[33:25];
            got.receive_count   = m_axis_tdata[42:34];
            got.completion_code = m_axis_tdata[45:43];
            got.request_address = m_axis_tdata[69:46];
            got.request_length  = m_axis_tdata[85:70];
            got.data_ready      = m_axis_tdata[86];
            if (pending_beats.size() == 0)
            begin
                $display("%0t ns: unexpected beat, expected none, actual tuser %0b tdata 0x%0h",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_beats.pop_front();
                compare_field("kind", 24'(want.kind), 24'(got.kind));
                compare_field("command", 24'(want.command), 24'(got.command));
                compare_field("address_top", 24'(want.address_top), 24'(got.address_top));
                compare_field("address_mid", 24'(want.address_mid), 24'(got.address_mid));
                compare_field("address_bottom", 24'(want.address_bottom),
                              24'(got.address_bottom));
                compare_field("send_count", 24'(want.send_count), 24'(got.send_count));
                compare_field("receive_count", 24'(want.receive_count),
                              24'(got.receive_count));
                compare_field("completion_code", 24'(want.completion_code),
                              24'(got.completion_code));
                compare_field("request_address", want.request_address,
                              got.request_address);
                compare_field("request_length", 24'(want.request_length),
                              24'(got.request_length));
                compare_field("data_ready", 24'(want.data_ready), 24'(got.data_ready));
            end
            // count the beat; the ready process draws the next stall
            beats_seen++;
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout with %0d beats outstanding", $time, pending_beats.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Random event generation
    // ------------------------------------------------------------------------
    function automatic event_t draw_noise_event();
        event_t ev;
        ev.operation         = op_t'(2'($urandom_range(0, 3)));
        ev.address           = 24'($urandom);
        ev.length            = 16'($urandom);
        ev.buffer_present    = 1'($urandom);
        ev.transfer_accepted = 1'($urandom);
        ev.status_byte       = 8'($urandom);
        return ev;
    endfunction

    // Pick the event that moves the current sequence on, with random content
    function automatic event_t draw_sequence_event();
        event_t      ev;
        int unsigned len;
        int unsigned top;
        ev = draw_noise_event();
        ev.transfer_accepted = ($urandom_range(0, 15) != 0);
        top = int'(MEM_LIMIT);
        case (seq_phase)
            PH_NOINIT, PH_ERROR: ev.operation = OP_INIT;
            PH_INIT:
            begin
                ev.operation = OP_FINISH;
                if ($urandom_range(0, 7) != 0)
                    ev.status_byte = 8'h00;
            end
            PH_IDLE:
            begin
                ev.operation = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
                ev.buffer_present = ($urandom_range(0, 31) != 0);
                case ($urandom_range(0, 15))
                    0:       len = 256;
                    1:       len = 0;
                    2:       len = $urandom_range(257, 65535);
                    default: len = $urandom_range(1, 256);
                endcase
                ev.length = 16'(len);
                case ($urandom_range(0, 15))
                    0:       ev.address = 24'(top - len + 1);
                    1:       ev.address = 24'(top - len);
                    default: ev.address = 24'($urandom_range(0, top - len));
                endcase
            end
            default: ev.operation = OP_FINISH;
        endcase
        return ev;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_before_init();
        // requests before init are busy; a finish with nothing in flight is dropped
        send_event(compose_event(OP_READ, 24'h000100, 16'd16, 1'b1, 1'b1, 8'h00));
        send_event(compose_event(OP_FINISH, 24'h0, 16'd0, 1'b0, 1'b1, 8'h00));
    endtask

    task automatic test_init_paths();
        send_event(compose_event(OP_INIT, 24'h0, 16'd0, 1'b0, 1'b0, 8'h00));
        send_event(compose_event(OP_READ, 24'hFFFFFF, 16'hFFFF, 1'b1, 1'b1, 8'hFF));
        send_event(compose_event(OP_INIT, 24'h0, 16'd0, 1'b0, 1'b1, 8'h00));
        send_event(compose_event(OP_FINISH, 24'h0, 16'd0, 1'b0, 1'b1, 8'h80));
        send_event(compose_event(OP_INIT, 24'h0, 16'd0, 1'b0, 1'b1, 8'h00));
        send_event(compose_event(OP_FINISH, 24'h0, 16'd0, 1'b0, 1'b1, 8'h00));
    endtask

    task automatic test_read_paths();
        send_event(compose_event(OP_READ, 24'h000010, 16'd8, 1'b0, 1'b1, 8'h00));
        send_event(compose_event(OP_READ, 24'h000000, 16'd257, 1'b1, 1'b1, 8'h00));
        // length is checked before the address
        send_event(compose_event(OP_READ, 24'hFFFFFF, 16'hFFFF, 1'b1, 1'b1, 8'h00));
        send_event(compose_event(OP_READ, 24'h01FF01, 16'd256, 1'b1, 1'b1, 8'h00));
        send_event(compose_event(OP_READ, 24'h000200, 16'd4, 1'b1, 1'b0, 8'h00));
        send_event(compose_event(OP_READ, 24'h01FF00, 16'd256, 1'b1, 1'b1, 8'h00));
        send_event(compose_event(OP_WRITE, 24'h000000, 16'd1, 1'b1, 1'b1, 8'h00));
        send_event(compose_event(OP_FINISH, 24'h0, 16'd0, 1'b0, 1'b1, 8'h00));
        // zero length right at the top of memory is still in range
        send_event(compose_event(OP_READ, 24'h020000, 16'd0, 1'b1, 1'b1, 8'h00));
        send_event(compose_event(OP_FINISH, 24'h0, 16'd0, 1'b0, 1'b1, 8'h00));
    endtask

    task automatic test_write_paths();
        send_event(compose_event(OP_WRITE, 24'h010F0F, 16'd256, 1'b1, 1'b1, 8'h00));
        send_event(compose_event(OP_FINISH, 24'h0, 16'd0, 1'b0, 1'b1, 8'h00));
        send_event(compose_event(OP_FINISH, 24'h0, 16'd0, 1'b0, 1'b1, 8'h00));
        send_event(compose_event(OP_FINISH, 24'h0, 16'd0, 1'b0, 1'b1, 8'h00));
        // refused at the write-enable stage
        send_event(compose_event(OP_WRITE, 24'h00ABCD, 16'd17, 1'b1, 1'b1, 8'h00));
        send_event(compose_event(OP_FINISH, 24'h0, 16'd0, 1'b0, 1'b0, 8'h00));
        // refused at the data stage
        send_event(compose_event(OP_WRITE, 24'h01FFFF, 16'd1, 1'b1, 1'b1, 8'h00));
        send_event(compose_event(OP_FINISH, 24'h0, 16'd0, 1'b0, 1'b1, 8'h00));
        send_event(compose_event(OP_FINISH, 24'h0, 16'd0, 1'b0, 1'b0, 8'h00));
        // init in the middle of a write abandons it
        send_event(compose_event(OP_WRITE, 24'h000040, 16'd32, 1'b1, 1'b1, 8'h00));
        send_event(compose_event(OP_INIT, 24'h0, 16'd0, 1'b0, 1'b1, 8'h00));
        send_event(compose_event(OP_FINISH, 24'h0, 16'd0, 1'b0, 1'b1, 8'h00));
    endtask

    task automatic test_output_backpressure();
        int n;
        // hold ready low while events keep coming, so the input stream stalls
        tx_gaps_on = 1'b0;
        hold_requests++;
        for (n = 0; n < 16; n++)
            send_event(compose_event(OP_READ, 24'($urandom), 16'($urandom), 1'b0,
                                     1'($urandom), 8'($urandom)));
        wait_for_drain();
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int     items;
        event_t ev;
        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            // re-draw idling every stretch; some stretches run back to back
            if (items % 100 == 0)
            begin
                tx_gaps_on   = ($urandom_range(0, 3) != 0);
                rx_stalls_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) < 85)
                ev = draw_sequence_event();
            else
                ev = draw_noise_event();
            send_event(ev);
            items++;
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        test_before_init();
        test_init_paths();
        test_read_paths();
        test_write_paths();
        test_output_backpressure();
        test_random_traffic();
        wait_for_drain();
        if (mismatch_count == 0 && pending_beats.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
